/* hdl/blg_pkg.sv */
// Shared types, constants and helper functions of the battery level gauge.
`timescale 1ns / 1ps

package blg_pkg;

  // Default number of battery samples averaged per window.
  localparam int unsigned SAMPLE_COUNT_DEFAULT = 20;
  // Number of frames in the charging animation.
  localparam int unsigned ICON_FRAMES = 6;
  // Resolution of the ADC; samples are masked to this many bits.
  localparam int unsigned ADC_BITS = 12;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned REG_W = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [REG_W-1:0] MV_FULL = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHOW  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_MV        = 3'd0,
    REG_BATTERY_GAIN  = 3'd1,
    REG_MAINS_THRESH  = 3'd2,
    REG_LEVEL20       = 3'd3,
    REG_LEVEL40       = 3'd4,
    REG_LEVEL60       = 3'd5,
    REG_LEVEL80       = 3'd6,
    REG_LEVEL100      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] mains_raw;
    logic [SAMPLE_W-1:0] mains_vref_raw;
    logic                charging;
    logic                on_main_page;
    logic [SAMPLE_W-1:0] battery_raw;
    logic [SAMPLE_W-1:0] battery_vref_raw;
  } in_item_t;

  typedef struct packed {
    logic       mains_present;
    action_e    display_action;
    logic [2:0] icon_index;
    logic [6:0] capacity_pct;
    logic       capacity_valid;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] ref_mv;
    logic [REG_W-1:0] battery_gain_q12;
    logic [REG_W-1:0] mains_threshold_mv;
    logic [REG_W-1:0] level20_mv;
    logic [REG_W-1:0] level40_mv;
    logic [REG_W-1:0] level60_mv;
    logic [REG_W-1:0] level80_mv;
    logic [REG_W-1:0] level100_mv;
  } cfg_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_MAINS_RAW = 2'd0,
    MUL_MAINS_THR = 2'd1,
    MUL_BAT_REF   = 2'd2,
    MUL_BAT_GAIN  = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     div_load_mv;
    logic     div_step;
    logic     accum;
    logic     avg_mul;
    logic     fin_tick;
    logic     fin_win;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic win_last;
    logic out_free;
  } ctrl_stat_t;

  // Capacity level (0..5) to percent.
  function automatic logic [6:0] level_to_pct(input logic [2:0] lvl);
    logic [6:0] pct;
    unique case (lvl)
      3'd0:    pct = 7'd0;
      3'd1:    pct = 7'd20;
      3'd2:    pct = 7'd40;
      3'd3:    pct = 7'd60;
      3'd4:    pct = 7'd80;
      default: pct = 7'd100;
    endcase
    return pct;
  endfunction

endpackage

/* hdl/blg_cfg_regs.sv */
// Configuration register file of the battery level gauge.
`timescale 1ns / 1ps

module blg_cfg_regs import blg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_mv             <= 16'd1240;
      cfg_q.battery_gain_q12   <= 16'd19115;
      cfg_q.mains_threshold_mv <= 16'd2500;
      cfg_q.level20_mv         <= 16'd10800;
      cfg_q.level40_mv         <= 16'd11800;
      cfg_q.level60_mv         <= 16'd12400;
      cfg_q.level80_mv         <= 16'd13000;
      cfg_q.level100_mv        <= 16'd13400;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_REF_MV:       cfg_q.ref_mv             <= cfg_data_i;
        REG_BATTERY_GAIN: cfg_q.battery_gain_q12   <= cfg_data_i;
        REG_MAINS_THRESH: cfg_q.mains_threshold_mv <= cfg_data_i;
        REG_LEVEL20:      cfg_q.level20_mv         <= cfg_data_i;
        REG_LEVEL40:      cfg_q.level40_mv         <= cfg_data_i;
        REG_LEVEL60:      cfg_q.level60_mv         <= cfg_data_i;
        REG_LEVEL80:      cfg_q.level80_mv         <= cfg_data_i;
        REG_LEVEL100:     cfg_q.level100_mv        <= cfg_data_i;
      endcase
    end
  end

endmodule

/* hdl/blg_ctrl.sv */
// Sequencing state machine of the battery level gauge.
`timescale 1ns / 1ps

module blg_ctrl import blg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_ready_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_MAINS_A  = 11'b00000000010,
    S_MAINS_B  = 11'b00000000100,
    S_TICK_FIN = 11'b00000001000,
    S_BAT_A    = 11'b00000010000,
    S_BAT_B    = 11'b00000100000,
    S_DIV_LOAD = 11'b00001000000,
    S_DIV_RUN  = 11'b00010000000,
    S_ACCUM    = 11'b00100000000,
    S_AVG_RUN  = 11'b01000000000,
    S_WIN_FIN  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = in_kind_i ? S_BAT_A : S_MAINS_A;
        end
      end
      S_MAINS_A: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_MAINS_RAW;
        state_d = S_MAINS_B;
      end
      S_MAINS_B: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_MAINS_THR;
        state_d = S_TICK_FIN;
      end
      S_TICK_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin_tick = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_BAT_A: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BAT_REF;
        state_d = S_BAT_B;
      end
      S_BAT_B: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BAT_GAIN;
        state_d = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd_o.div_load_mv = 1'b1;
        state_d = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d = stat_i.win_last ? S_AVG_RUN : S_IDLE;
      end
      S_AVG_RUN: begin
        cmd_o.avg_mul = 1'b1;
        state_d = S_WIN_FIN;
      end
      S_WIN_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin_win = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/blg_datapath.sv */
// Datapath of the battery level gauge: multiplier, serial divider, window and hold state.
`timescale 1ns / 1ps

module blg_datapath import blg_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = SAMPLE_COUNT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_item_i,
  input  cfg_t       cfg_i,
  input  ctrl_cmd_t  cmd_i,
  output ctrl_stat_t stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  localparam int unsigned CntW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(SAMPLE_COUNT - 1);
  localparam logic [3:0] FramesN = 4'(ICON_FRAMES);
  // The average is the 21-bit window sum times a rounded-up reciprocal of
  // SAMPLE_COUNT; one extra fraction bit per bit of the divisor keeps it exact.
  localparam int unsigned AvgShift = 21 + $clog2(SAMPLE_COUNT);
  localparam logic [21:0] AvgMul =
    22'(((64'd1 << AvgShift) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

  // Payload registers.
  in_item_t            item_q;
  logic [43:0]         prod_q;
  logic [27:0]         keep_q;
  logic [SAMPLE_W-1:0] rem_q;
  logic [SAMPLE_W-1:0] dvsr_q;
  logic [20:0]         dvd_q;
  logic [20:0]         quo_q;
  logic                sat_q;
  logic [4:0]          step_q;

  // Control and result state.
  logic [20:0]     mv_sum_q;
  logic [CntW-1:0] cnt_q;
  logic [2:0]      held_q;
  logic            fresh_q;
  logic [2:0]      frame_q;
  logic            out_valid_q;
  out_item_t       out_q;

  logic [SAMPLE_W-1:0] mains_raw_m, mains_vref_m, bat_raw_m, bat_vref_m;
  logic [27:0]         mul_a;
  logic [15:0]         mul_b;
  logic [43:0]         mul_p;
  logic [42:0]         avg_p;
  logic [12:0]         trial;
  logic                fits;
  logic [SAMPLE_W-1:0] rem_nx;
  logic [15:0]         mv;
  logic [20:0]         sum_nx;
  logic [15:0]         avg;
  logic [2:0]          lvl;
  logic                take;
  logic [2:0]          held_nx;
  logic                present;
  logic [2:0]          shown;
  logic [3:0]          shown_inc;
  logic [2:0]          frame_nx;

  assign mains_raw_m  = item_q.mains_raw & ADC_MASK;
  assign mains_vref_m = item_q.mains_vref_raw & ADC_MASK;
  assign bat_raw_m    = item_q.battery_raw & ADC_MASK;
  assign bat_vref_m   = item_q.battery_vref_raw & ADC_MASK;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_MAINS_RAW: begin
        mul_a = 28'(mains_raw_m);
        mul_b = cfg_i.ref_mv;
      end
      MUL_MAINS_THR: begin
        mul_a = 28'(cfg_i.mains_threshold_mv);
        mul_b = 16'(mains_vref_m);
      end
      MUL_BAT_REF: begin
        mul_a = 28'(bat_raw_m);
        mul_b = cfg_i.ref_mv;
      end
      MUL_BAT_GAIN: begin
        mul_a = prod_q[27:0];
        mul_b = cfg_i.battery_gain_q12;
      end
    endcase
  end

  assign mul_p = 44'(mul_a) * 44'(mul_b);

  // The window sum waits in dvd_q while its average is formed.
  assign avg_p = 43'(dvd_q) * 43'(AvgMul);

  // Restoring division step, one quotient bit per cycle.
  assign trial  = {rem_q, dvd_q[20]};
  assign fits   = trial >= {1'b0, dvsr_q};
  assign rem_nx = fits ? SAMPLE_W'(trial - {1'b0, dvsr_q}) : trial[SAMPLE_W-1:0];

  assign mv     = sat_q ? MV_FULL : quo_q[15:0];
  assign sum_nx = mv_sum_q + 21'(mv);
  assign avg    = quo_q[15:0];

  always_comb begin
    if (avg < cfg_i.level20_mv) begin
      lvl = 3'd0;
    end else if (avg < cfg_i.level40_mv) begin
      lvl = 3'd1;
    end else if (avg < cfg_i.level60_mv) begin
      lvl = 3'd2;
    end else if (avg < cfg_i.level80_mv) begin
      lvl = 3'd3;
    end else if (avg < cfg_i.level100_mv) begin
      lvl = 3'd4;
    end else begin
      lvl = 3'd5;
    end
  end

  assign take    = fresh_q || (lvl < held_q);
  assign held_nx = take ? lvl : held_q;

  assign present   = keep_q >= prod_q[27:0];
  assign shown     = ({1'b0, frame_q} < FramesN) ? frame_q : 3'd0;
  assign shown_inc = {1'b0, shown} + 4'd1;
  assign frame_nx  = (shown_inc >= FramesN) ? 3'd0 : shown_inc[2:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
      if (cmd_i.mul_sel == MUL_MAINS_THR) begin
        keep_q <= prod_q[27:0];
      end
    end
    if (cmd_i.div_load_mv) begin
      // The quotient fits 16 bits unless the high part reaches the divisor.
      sat_q  <= (bat_vref_m == '0) || (prod_q[43:28] >= 16'(bat_vref_m));
      rem_q  <= prod_q[39:28];
      dvd_q  <= {prod_q[27:12], 5'd0};
      dvsr_q <= bat_vref_m;
      step_q <= 5'd16;
    end else if (cmd_i.accum && (cnt_q == CntLast)) begin
      dvd_q <= sum_nx;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_nx;
      dvd_q  <= {dvd_q[19:0], 1'b0};
      quo_q  <= {quo_q[19:0], fits};
      step_q <= step_q - 5'd1;
    end
    if (cmd_i.avg_mul) begin
      quo_q <= 21'(avg_p >> AvgShift);
    end
    if (cmd_i.fin_tick) begin
      out_q.mains_present  <= present;
      out_q.display_action <= ACT_NONE;
      out_q.icon_index     <= 3'd0;
      out_q.capacity_pct   <= 7'd0;
      out_q.capacity_valid <= 1'b0;
      if (present && item_q.on_main_page) begin
        if (item_q.charging) begin
          out_q.display_action <= ACT_SHOW;
          out_q.icon_index     <= shown;
        end else begin
          out_q.display_action <= ACT_CLEAR;
        end
      end
    end else if (cmd_i.fin_win) begin
      out_q.mains_present  <= 1'b0;
      out_q.display_action <= item_q.on_main_page ? ACT_SHOW : ACT_NONE;
      out_q.icon_index     <= item_q.on_main_page ? held_nx : 3'd0;
      out_q.capacity_pct   <= level_to_pct(held_nx);
      out_q.capacity_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_sum_q    <= '0;
      cnt_q       <= '0;
      held_q      <= '0;
      fresh_q     <= 1'b1;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accum) begin
        if (cnt_q == CntLast) begin
          mv_sum_q <= '0;
          cnt_q    <= '0;
        end else begin
          mv_sum_q <= sum_nx;
          cnt_q    <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.fin_tick && present && item_q.on_main_page && item_q.charging) begin
        fresh_q <= 1'b1;
        frame_q <= frame_nx;
      end
      if (cmd_i.fin_win) begin
        if (take) begin
          fresh_q <= 1'b0;
        end
        held_q  <= held_nx;
        frame_q <= held_nx;
      end
      if (cmd_i.fin_tick || cmd_i.fin_win) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.div_last = (step_q == 5'd1);
  assign stat_o.win_last = (cnt_q == CntLast);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* hdl/battery_level_gauge_top.sv */
// Top level of the battery level gauge: mains detection, charge animation and capacity.
`timescale 1ns / 1ps

// The gauge takes one item at a time. A status tick (kind 0) decides whether
// mains is present by comparing mains_raw*ref_mv against
// mains_threshold_mv*mains_vref_raw on a shared 28x16 multiplier; it passes
// through the states MAINS_A and MAINS_B to TICK_FIN, where it waits until
// the output register is free and registers its result. A battery sample
// (kind 1) is scaled to millivolts through two multiplier passes and a
// 16-step restoring divider, one quotient bit per cycle, and is added to the
// window sum; it gives no result. The sample that closes a window of
// SAMPLE_COUNT samples forms the average by multiplying the sum with a fixed
// reciprocal of SAMPLE_COUNT in the AVG_RUN state, then gives one result
// carrying the capacity in steps of 20 percent. A finished result sits in an
// output register, so the next item is accepted while it waits to be taken;
// a result only stalls the gauge when a second one is ready before the first
// has left. The held capacity can only fall until a charging tick on the
// main page with mains present rearms it. Configuration registers may be
// written at any time the gauge is idle; the write port is always ready. No
// clearing pass is needed after reset.
module battery_level_gauge_top import blg_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = SAMPLE_COUNT_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  blg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The controller sequences the multiplier and divider passes of each item, the window sum and the output.
  blg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_item_i.kind),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the arithmetic, the window sum and the hold state.
  blg_datapath #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // One item at a time: right after an accept the gauge is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("gauge accepted an item while busy");

  // Clearing the icon only happens on a tick that saw mains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.display_action == ACT_CLEAR) |->
      out_item_o.mains_present && !out_item_o.capacity_valid)
    else $error("icon cleared without mains");

  // A window result carries a capacity in steps of 20 percent and its icon matches.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.capacity_valid && (out_item_o.display_action == ACT_SHOW) |->
      (out_item_o.capacity_pct == level_to_pct(out_item_o.icon_index)) &&
      (out_item_o.icon_index <= 3'd5))
    else $error("window result capacity and icon disagree");

endmodule
